### sv/palette_color_allocator_defines.svh
// Assertion macros used by the palette allocator
`ifndef PALETTE_COLOR_ALLOCATOR_DEFINES_SVH
`define PALETTE_COLOR_ALLOCATOR_DEFINES_SVH

// Implication checked on every rising clock edge outside reset
`define PCA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the cycle after the antecedent
`define PCA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/pca_pkg.sv
// Shared constants and types for the palette allocator
package pca_pkg;
  localparam int unsigned PaletteSize = 16;
  localparam int unsigned CompBits    = 8;
  localparam int unsigned CountBits   = 16;
  localparam int unsigned IdxW        = $clog2(PaletteSize);
  localparam int unsigned DistW       = 18;
  localparam int unsigned SqW         = 2 * CompBits;
  localparam int unsigned SumW        = SqW + 2;

  localparam logic [1:0] ReqAlloc   = 2'd0;
  localparam logic [1:0] ReqRelease = 2'd1;
  localparam logic [1:0] ReqLoad    = 2'd2;
  localparam logic [1:0] ReqUnknown = 2'd3;

  localparam logic [1:0] KindExact   = 2'd0;
  localparam logic [1:0] KindNew     = 2'd1;
  localparam logic [1:0] KindNearest = 2'd2;
  localparam logic [1:0] KindNone    = 2'd3;

  localparam logic [1:0] CfgColors   = 2'd0;
  localparam logic [1:0] CfgRedefine = 2'd1;
  localparam logic [1:0] CfgReadonly = 2'd2;

  typedef struct packed {
    logic [CompBits-1:0] r;
    logic [CompBits-1:0] g;
    logic [CompBits-1:0] b;
  } rgb_t;

  // Token walking down the chain of cells
  typedef struct packed {
    logic                valid;
    logic [IdxW-1:0]     pos;     // index of the cell that receives it
    logic                alloc;   // search request
    logic                wr;      // commit request
    logic [1:0]          op;      // commit operation
    logic [IdxW-1:0]     tgt;     // commit target
    rgb_t                col;
  } tok_t;

  localparam logic [1:0] OpBump = 2'd0;
  localparam logic [1:0] OpNew  = 2'd1;
  localparam logic [1:0] OpDec  = 2'd2;
  localparam logic [1:0] OpLoad = 2'd3;

  // What a cell reports to the controller while the search token passes
  typedef struct packed {
    logic               exact;
    logic               free;
    logic [SumW-1:0]    sq_sum;
  } cell_rep_t;
endpackage

### sv/pca_cell.sv
// One palette entry: colour, count and a stage of the token chain
module pca_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [pca_pkg::IdxW-1:0]             my_idx_i,
  input  logic                                 readonly_i,
  input  pca_pkg::tok_t                        tok_i,
  output pca_pkg::tok_t                        tok_o,
  output pca_pkg::cell_rep_t                   rep_o,
  output logic                                 cnt_zero_o
);
  pca_pkg::rgb_t                     col_q;
  logic [pca_pkg::CountBits-1:0]     cnt_q;
  logic [pca_pkg::CompBits-1:0]      dr, dg, db;
  logic [pca_pkg::SqW-1:0]           sr, sg, sb;
  logic                              hit;
  pca_pkg::tok_t                     tok_d;

  assign hit = tok_i.valid && (tok_i.pos == my_idx_i);

  always_comb begin
    dr = (tok_i.col.r >= col_q.r) ? tok_i.col.r - col_q.r : col_q.r - tok_i.col.r;
    dg = (tok_i.col.g >= col_q.g) ? tok_i.col.g - col_q.g : col_q.g - tok_i.col.g;
    db = (tok_i.col.b >= col_q.b) ? tok_i.col.b - col_q.b : col_q.b - tok_i.col.b;
    sr = dr * dr;
    sg = dg * dg;
    sb = db * db;
    rep_o.exact  = (col_q == tok_i.col);
    rep_o.free   = (cnt_q == '0) && !readonly_i;
    rep_o.sq_sum = pca_pkg::SumW'(sr) + pca_pkg::SumW'(sg) + pca_pkg::SumW'(sb);
  end

  assign cnt_zero_o = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      cnt_q <= '0;
    end else if (hit && tok_i.wr && tok_i.tgt == my_idx_i) begin
      unique case (tok_i.op)
        pca_pkg::OpBump: if (cnt_q != '1) cnt_q <= cnt_q + 1'b1;
        pca_pkg::OpNew: begin
          col_q <= tok_i.col;
          cnt_q <= pca_pkg::CountBits'(1);
        end
        pca_pkg::OpDec:  if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
        default:         col_q <= tok_i.col;
      endcase
    end
  end

  always_comb begin
    tok_d       = tok_i;
    tok_d.valid = hit;
    tok_d.pos   = tok_i.pos + 1'b1;
  end

  // Hand the token on to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_o <= '0;
    end else begin
      tok_o <= tok_d;
    end
  end
endmodule

### sv/palette_color_allocator.sv
// Palette allocator: chain of entry cells walked by a token, plus control
// An allocate walks a search token over n active entries, then a commit over 16 cells;
// release, load and unknown requests make only the commit walk.
// Throughput: one request at a time; the next may be accepted in the strobe cycle,
// and results cannot be held off.
// Reset: black colours, zero counts, 16 entries, redefinition on, nothing read-only.
`include "palette_color_allocator_defines.svh"
module palette_color_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [3:0]  entry_index_i,
  output logic        done_o,
  output logic [3:0]  color_index_o,
  output logic [1:0]  match_kind_o,
  output logic [17:0] best_distance_o,
  output logic        error_o
);
  localparam int unsigned N = pca_pkg::PaletteSize;
  localparam int unsigned W = pca_pkg::IdxW;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StSearch = 2'd1;
  localparam logic [1:0] StCommit = 2'd2;

  logic [4:0]  colors_q;
  logic        redef_q;
  logic [15:0] ro_q;

  logic [1:0]  st_q;
  logic [W:0]  n_act;
  logic [W:0]  cnt_q;
  pca_pkg::tok_t      tok_in;
  pca_pkg::tok_t      chain [N+1];
  pca_pkg::cell_rep_t rep   [N];
  logic [N-1:0]       zero;

  // search bookkeeping
  logic            ex_f_q, fr_f_q;
  logic [W-1:0]    ex_i_q, fr_i_q, nb_i_q;
  logic [pca_pkg::SumW-1:0] nb_d_q;
  logic [W-1:0]    res_idx_q;
  logic [1:0]      res_kind_q;
  logic [17:0]     res_dist_q;
  logic            res_err_q;
  pca_pkg::rgb_t   col_q;
  logic            accept;
  logic            acc_err;

  assign n_act = (colors_q == 5'd0) ? (W+1)'(1) :
                 (colors_q > 5'(N)) ? (W+1)'(N) : (W+1)'(colors_q);
  assign accept = start && !busy;
  assign busy   = (st_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colors_q <= 5'd16;
      redef_q  <= 1'b1;
      ro_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pca_pkg::CfgColors:   colors_q <= cfg_data_i[4:0];
        pca_pkg::CfgRedefine: redef_q  <= cfg_data_i[0];
        pca_pkg::CfgReadonly: ro_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign chain[0] = tok_in;
  for (genvar k = 0; k < N; k++) begin : g_cell
    pca_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .my_idx_i   (W'(k)),
      .readonly_i (ro_q[k]),
      .tok_i      (chain[k]),
      .tok_o      (chain[k+1]),
      .rep_o      (rep[k]),
      .cnt_zero_o (zero[k])
    );
  end

  // Pick the report of the cell holding the search token
  pca_pkg::cell_rep_t cur_rep;
  logic               cur_v;
  logic [W-1:0]       cur_i;
  always_comb begin
    cur_rep = '0;
    cur_v   = 1'b0;
    cur_i   = '0;
    for (int k = 0; k < N; k++) begin
      if (chain[k].valid && chain[k].alloc && (W+1)'(k) < n_act) begin
        cur_rep = rep[k];
        cur_v   = 1'b1;
        cur_i   = W'(k);
      end
    end
  end

  always_comb begin
    tok_in = '0;
    if (accept) begin
      tok_in.valid = 1'b1;
      tok_in.col   = '{r: red_i, g: green_i, b: blue_i};
      if (req_type_i == pca_pkg::ReqAlloc) begin
        tok_in.alloc = 1'b1;
      end else if (req_type_i == pca_pkg::ReqRelease) begin
        tok_in.wr  = ((W+1)'(entry_index_i) < n_act) && !zero[entry_index_i];
        tok_in.op  = pca_pkg::OpDec;
        tok_in.tgt = entry_index_i;
      end else if (req_type_i == pca_pkg::ReqLoad) begin
        tok_in.wr  = ((W+1)'(entry_index_i) < n_act);
        tok_in.op  = pca_pkg::OpLoad;
        tok_in.tgt = entry_index_i;
      end
    end else if (st_q == StSearch && cnt_q == n_act) begin
      // Launch the commit walk with the search outcome
      tok_in.valid = 1'b1;
      tok_in.wr    = 1'b1;
      tok_in.col   = col_q;
      if (ex_f_q) begin
        tok_in.op = pca_pkg::OpBump; tok_in.tgt = ex_i_q;
      end else if (fr_f_q && redef_q) begin
        tok_in.op = pca_pkg::OpNew;  tok_in.tgt = fr_i_q;
      end else begin
        tok_in.op = pca_pkg::OpBump; tok_in.tgt = nb_i_q;
      end
    end
  end

  always_comb begin
    unique case (req_type_i)
      pca_pkg::ReqAlloc:   acc_err = 1'b0;
      pca_pkg::ReqRelease: acc_err = ((W+1)'(entry_index_i) >= n_act) || zero[entry_index_i];
      pca_pkg::ReqLoad:    acc_err = ((W+1)'(entry_index_i) >= n_act);
      default:             acc_err = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= (st_q == StCommit) && (cnt_q == (W+1)'(N));
      unique case (st_q)
        StIdle: if (accept) begin
          cnt_q <= '0;
          st_q  <= (req_type_i == pca_pkg::ReqAlloc) ? StSearch : StCommit;
        end
        StSearch: begin
          if (cnt_q == n_act) begin
            cnt_q <= '0;
            st_q  <= StCommit;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        StCommit: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == (W+1)'(N)) st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q  <= '{r: red_i, g: green_i, b: blue_i};
      // Cell 0 reports in the accepting cycle: seed the search with it
      ex_f_q <= cur_v && cur_rep.exact;
      ex_i_q <= '0;
      fr_f_q <= cur_v && cur_rep.free;
      fr_i_q <= '0;
      nb_i_q <= '0;
      nb_d_q <= cur_v ? cur_rep.sq_sum : '1;
      res_idx_q  <= (req_type_i == pca_pkg::ReqRelease || req_type_i == pca_pkg::ReqLoad) ?
                    entry_index_i : '0;
      res_kind_q <= pca_pkg::KindNone;
      res_dist_q <= '0;
      res_err_q  <= acc_err;
    end else if (st_q == StSearch) begin
      if (cur_v) begin
        if (cur_rep.exact && !ex_f_q) begin
          ex_f_q <= 1'b1; ex_i_q <= cur_i;
        end
        if (cur_rep.free && !fr_f_q) begin
          fr_f_q <= 1'b1; fr_i_q <= cur_i;
        end
        if (cur_rep.sq_sum < nb_d_q) begin
          nb_d_q <= cur_rep.sq_sum; nb_i_q <= cur_i;
        end
      end
      if (cnt_q == n_act) begin
        if (ex_f_q) begin
          res_idx_q <= ex_i_q; res_kind_q <= pca_pkg::KindExact;
        end else if (fr_f_q && redef_q) begin
          res_idx_q <= fr_i_q; res_kind_q <= pca_pkg::KindNew;
        end else begin
          res_idx_q  <= nb_i_q; res_kind_q <= pca_pkg::KindNearest;
          res_dist_q <= nb_d_q[17:0];
        end
      end
    end
  end

  assign color_index_o   = res_idx_q;
  assign match_kind_o    = res_kind_q;
  assign best_distance_o = res_dist_q;
  assign error_o         = res_err_q;

  `PCA_ASSERT_IMPL(a_done_idle, clk_i, rst_ni, done_o, st_q == StIdle)
  `PCA_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, accept, busy)
  `PCA_ASSERT_IMPL(a_exact_nodist, clk_i, rst_ni, done_o && match_kind_o != pca_pkg::KindNearest,
                   best_distance_o == 18'd0)
endmodule
